### rtl/core/ihex_pkg.sv
// types, constants and the control program of the hex record encoder
`default_nettype none

package ihex_pkg;

  localparam int DEFAULT_RECORD_BYTES = 16;
  localparam int DEFAULT_ADDRESS_BITS = 24;
  localparam int CFG_W                = 24;
  localparam int PC_W                 = 5;

  // entry points of the control program
  localparam logic [PC_W-1:0] PC_ELA = 5'd0;
  localparam logic [PC_W-1:0] PC_DAT = 5'd9;
  localparam logic [PC_W-1:0] PC_EOF = 5'd17;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_run;
  } out_item_t;

  typedef enum logic [0:0] {
    OP_CHAR,
    OP_HEX
  } op_t;

  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_UP,
    SRC_LEN,
    SRC_OFFHI,
    SRC_OFFLO,
    SRC_BUF,
    SRC_CKS
  } src_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_LOOP,
    BR_CLOSE,
    BR_LAST,
    BR_END
  } br_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } seq_state_t;

  typedef struct packed {
    op_t             op;
    src_t            src;
    logic [7:0]      lit;
    br_t             br;
    logic [PC_W-1:0] target;
    logic            clr_cks;
    logic            clr_count;
    logic            restart;
  } ctrl_t;

  typedef struct packed {
    logic close;
    logic last;
    logic more;
  } cond_t;

  typedef struct packed {
    ctrl_t word;
    logic  phase;
    logic  fire;
    logic  step_done;
    logic  eor;
  } step_t;

  function automatic ctrl_t mk(input op_t op, input src_t src, input logic [7:0] lit,
                               input br_t br, input logic [PC_W-1:0] target,
                               input logic clr_cks, input logic clr_count,
                               input logic restart);
    ctrl_t w;
    w.op        = op;
    w.src       = src;
    w.lit       = lit;
    w.br        = br;
    w.target    = target;
    w.clr_cks   = clr_cks;
    w.clr_count = clr_count;
    w.restart   = restart;
    return w;
  endfunction

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      // extended linear address record
      5'd0:  w = mk(OP_CHAR, SRC_LIT,   CH_COLON,   BR_NEXT,  PC_ELA, 1'b1, 1'b0, 1'b0);
      5'd1:  w = mk(OP_HEX,  SRC_LIT,   8'h02,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd2:  w = mk(OP_HEX,  SRC_LIT,   8'h00,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd3:  w = mk(OP_HEX,  SRC_LIT,   8'h00,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd4:  w = mk(OP_HEX,  SRC_LIT,   8'h04,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd5:  w = mk(OP_HEX,  SRC_LIT,   8'h00,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd6:  w = mk(OP_HEX,  SRC_UP,    8'h00,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd7:  w = mk(OP_HEX,  SRC_CKS,   8'h00,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd8:  w = mk(OP_CHAR, SRC_LIT,   CH_NEWLINE, BR_CLOSE, PC_DAT, 1'b0, 1'b0, 1'b0);
      // data record
      5'd9:  w = mk(OP_CHAR, SRC_LIT,   CH_COLON,   BR_NEXT,  PC_ELA, 1'b1, 1'b0, 1'b0);
      5'd10: w = mk(OP_HEX,  SRC_LEN,   8'h00,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd11: w = mk(OP_HEX,  SRC_OFFHI, 8'h00,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd12: w = mk(OP_HEX,  SRC_OFFLO, 8'h00,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd13: w = mk(OP_HEX,  SRC_LIT,   8'h00,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd14: w = mk(OP_HEX,  SRC_BUF,   8'h00,      BR_LOOP,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd15: w = mk(OP_HEX,  SRC_CKS,   8'h00,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd16: w = mk(OP_CHAR, SRC_LIT,   CH_NEWLINE, BR_LAST,  PC_EOF, 1'b0, 1'b1, 1'b0);
      // end of file record
      5'd17: w = mk(OP_CHAR, SRC_LIT,   CH_COLON,   BR_NEXT,  PC_ELA, 1'b1, 1'b0, 1'b0);
      5'd18: w = mk(OP_HEX,  SRC_LIT,   8'h00,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd19: w = mk(OP_HEX,  SRC_LIT,   8'h00,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd20: w = mk(OP_HEX,  SRC_LIT,   8'h00,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd21: w = mk(OP_HEX,  SRC_LIT,   8'h01,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd22: w = mk(OP_HEX,  SRC_LIT,   8'hFF,      BR_NEXT,  PC_ELA, 1'b0, 1'b0, 1'b0);
      5'd23: w = mk(OP_CHAR, SRC_LIT,   CH_NEWLINE, BR_END,   PC_ELA, 1'b0, 1'b0, 1'b1);
      default: w = mk(OP_CHAR, SRC_LIT, CH_NEWLINE, BR_END,   PC_ELA, 1'b0, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/intel_hex_record_encoder.sv
// top level: byte buffer, address tracking and character datapath of the hex encoder
`default_nettype none

// Takes memory bytes one request at a time, starting at the address written on cfg_data, and streams
// Intel HEX text out one ASCII character per request. A byte that closes no record and
// needs no extended linear address record is taken without a stall and produces nothing.
// Any other byte holds the input stalled while a small control program emits the text
// at one character per cycle unless out_stall holds it: 12 + 2*len characters for a data
// record, 16 for an extended linear address record that goes first and 12 more for the
// end of file record after the last byte. The one-character output register sets the pace.
// Writing cfg_data with cfg_we restarts the stream, as does the end of file record.
module intel_hex_record_encoder #(
  parameter int RECORD_BYTES = ihex_pkg::DEFAULT_RECORD_BYTES,
  parameter int ADDRESS_BITS = ihex_pkg::DEFAULT_ADDRESS_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ihex_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ihex_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [ihex_pkg::CFG_W-1:0]   cfg_data
);
  import ihex_pkg::*;

  localparam int CW      = $clog2(RECORD_BYTES + 1);
  localparam int IW      = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int UPPER_W = ADDRESS_BITS - 16;

  logic [7:0]              byte_buffer [RECORD_BYTES];
  logic [CW-1:0]           count;
  logic [ADDRESS_BITS-1:0] base_addr;
  logic [ADDRESS_BITS-1:0] next_address;
  logic [15:0]             record_offset;
  logic [UPPER_W-1:0]      emitted_upper;
  logic [UPPER_W-1:0]      up_reg;
  logic                    close_reg;
  logic                    last_reg;
  logic [IW-1:0]           idx;
  logic [7:0]              cks;

  logic                    accept;
  logic [UPPER_W-1:0]      up;
  logic                    ela_need;
  logic                    close;
  logic                    go;
  logic [PC_W-1:0]         entry;
  cond_t                   cond;
  logic                    adv;
  logic                    busy;
  step_t                   step;
  logic [7:0]              sel_byte;
  logic [7:0]              char;

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy;
  assign up       = next_address[ADDRESS_BITS-1:16];
  assign ela_need = (count == '0) && (up != emitted_upper);
  assign close    = in_item.last_byte || ((count + CW'(1)) == CW'(RECORD_BYTES))
                    || (next_address[15:0] == 16'hFFFF);
  assign go       = accept && (ela_need || close);
  assign entry    = ela_need ? PC_ELA : PC_DAT;
  assign adv      = !out_valid || !out_stall;

  always_comb begin
    cond.close = close_reg;
    cond.last  = last_reg;
    cond.more  = (CW'(idx) + CW'(1)) != count;
  end

  ihex_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .entry (entry),
    .cond  (cond),
    .adv   (adv),
    .busy  (busy),
    .step  (step)
  );

  always_comb begin
    unique case (step.word.src)
      SRC_LIT:   sel_byte = step.word.lit;
      SRC_UP:    sel_byte = 8'(up_reg);
      SRC_LEN:   sel_byte = 8'(count);
      SRC_OFFHI: sel_byte = record_offset[15:8];
      SRC_OFFLO: sel_byte = record_offset[7:0];
      SRC_BUF:   sel_byte = byte_buffer[idx];
      SRC_CKS:   sel_byte = 8'h00 - cks;
      default:   sel_byte = step.word.lit;
    endcase
    if (step.word.op == OP_CHAR) begin
      char = step.word.lit;
    end else if (step.phase) begin
      char = hex_char(sel_byte[3:0]);
    end else begin
      char = hex_char(sel_byte[7:4]);
    end
  end

  // open record buffer
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_buffer[count[IW-1:0]] <= in_item.data_byte;
    end
  end

  // per-record working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      up_reg    <= up;
      close_reg <= close;
      last_reg  <= in_item.last_byte;
    end
    if (step.fire && step.word.clr_cks) begin
      cks <= 8'h00;
      idx <= '0;
    end else if (step.fire && step.phase && step.word.op == OP_HEX) begin
      if (step.word.src != SRC_CKS) begin
        cks <= cks + sel_byte;
      end
      if (step.word.src == SRC_BUF) begin
        idx <= idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr     <= '0;
      count         <= '0;
      next_address  <= '0;
      record_offset <= 16'h0000;
      emitted_upper <= '0;
    end else if (cfg_we) begin
      base_addr     <= cfg_data[ADDRESS_BITS-1:0];
      count         <= '0;
      next_address  <= cfg_data[ADDRESS_BITS-1:0];
      record_offset <= cfg_data[15:0];
      emitted_upper <= cfg_data[ADDRESS_BITS-1:16];
    end else if (step.fire && step.word.restart) begin
      count         <= '0;
      next_address  <= base_addr;
      record_offset <= base_addr[15:0];
      emitted_upper <= base_addr[ADDRESS_BITS-1:16];
    end else if (step.fire && step.word.clr_count) begin
      count <= '0;
    end else if (accept) begin
      count        <= count + CW'(1);
      next_address <= next_address + ADDRESS_BITS'(1);
      if (count == '0) begin
        record_offset <= next_address[15:0];
      end
      if (ela_need) begin
        emitted_upper <= up;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      out_item.text_char  <= char;
      out_item.end_of_run <= step.eor;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ihex_seq.sv
// step counter and branch logic that walks the record control program
`default_nettype none

module ihex_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [ihex_pkg::PC_W-1:0] entry,
  input  ihex_pkg::cond_t           cond,
  input  logic                      adv,
  output logic                      busy,
  output ihex_pkg::step_t           step
);
  import ihex_pkg::*;

  seq_state_t      state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  logic            phase, phase_next;
  logic [PC_W-1:0] br_pc;
  ctrl_t           word;
  logic            fire;
  logic            step_done;
  logic            to_end;

  always_comb begin
    word      = ucode(pc);
    fire      = (state == S_RUN) && adv;
    // a hex step emits its high nibble first, then its low nibble
    step_done = (word.op == OP_CHAR) || phase;
    br_pc     = pc + PC_W'(1);
    to_end    = 1'b0;
    unique case (word.br)
      BR_NEXT: begin
        br_pc = pc + PC_W'(1);
      end
      BR_LOOP: begin
        br_pc = cond.more ? pc : pc + PC_W'(1);
      end
      BR_CLOSE: begin
        br_pc  = word.target;
        to_end = !cond.close;
      end
      BR_LAST: begin
        br_pc  = word.target;
        to_end = !cond.last;
      end
      BR_END: begin
        to_end = 1'b1;
      end
      default: begin
        to_end = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        if (go) begin
          state_next = S_RUN;
          pc_next    = entry;
          phase_next = 1'b0;
        end
      end
      S_RUN: begin
        if (fire) begin
          if (!step_done) begin
            phase_next = 1'b1;
          end else begin
            phase_next = 1'b0;
            pc_next    = br_pc;
            if (to_end) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= PC_ELA;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      phase <= phase_next;
    end
  end

  assign busy = (state == S_RUN);

  always_comb begin
    step.word      = word;
    step.phase     = phase;
    step.fire      = fire;
    step.step_done = step_done;
    step.eor       = fire && step_done && to_end;
  end

endmodule

`default_nettype wire

### rtl/core/ihex_checker.sv
// port-level checks of the hex encoder and their binding to the top level
`default_nettype none

module ihex_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input ihex_pkg::in_item_t         in_item,
  input logic                       out_valid,
  input logic                       out_stall,
  input ihex_pkg::out_item_t        out_item
);
  import ihex_pkg::*;

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output request changed");

  // the last byte always closes a record, so taking it starts record output and stalls the input
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_item.last_byte |=> in_stall)
    else $error("last byte did not start record output");

  // a run of text always ends on a newline
  a_eor_newline: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.end_of_run |-> out_item.text_char == CH_NEWLINE)
    else $error("end of run on a character other than newline");

  // new text is only produced while the input side is held off
  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output appeared while the sequencer was idle");

endmodule

bind intel_hex_record_encoder ihex_checker u_ihex_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
